/* hdl/npsnap_pkg.sv */
// Shared types and constants for the nearest point snap block.
// No dependencies; imported by every module of the block.
package npsnap_pkg;

    localparam int DEF_POINTS     = 1024;
    localparam int DEF_COORD_BITS = 24;

    localparam int IDX_W   = 10;
    localparam int COUNT_W = 11;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Register map: index taken from paddr[2]
    localparam logic REG_POINT_COUNT = 1'b0;

    // func field codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_SCAN,
        CMD_EMPTY
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [IDX_W-1:0]   slot;
        logic [IDX_W-1:0]   qidx;
        logic [COUNT_W-1:0] n;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } scan_state_t;

endpackage

/* hdl/nearest_point_snap.sv */
// Nearest point snap: a store of POINTS reference points is loaded one word at a
// time (func 0); a query word (func 1) is compared by exact squared distance
// against stored points 0 .. min(point_count, POINTS)-1 and answered with the
// index and coordinates of the nearest one, lowest index on a tie. Input words
// enter a four-deep command queue at one per cycle while it has room. The back
// end takes one load per cycle while idle; a query scans the single-port store
// one point per cycle and blocks other commands until its result is written.
// The store is not cleared after reset: load every point a query will search.
// Register point_count lies at byte address 0.
// Top level; uses npsnap_pkg, npsnap_front and npsnap_scan.
module nearest_point_snap #(
    parameter int POINTS     = npsnap_pkg::DEF_POINTS,
    parameter int COORD_BITS = npsnap_pkg::DEF_COORD_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [npsnap_pkg::PADDR_W-1:0]     paddr,
    input  logic [npsnap_pkg::PDATA_W-1:0]     pwdata,
    output logic [npsnap_pkg::PDATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               push,
    output logic                               full,
    input  logic                               func,
    input  logic [npsnap_pkg::IDX_W-1:0]       point_slot,
    input  logic [npsnap_pkg::IDX_W-1:0]       query_index,
    input  logic signed [COORD_BITS-1:0]       coord_x,
    input  logic signed [COORD_BITS-1:0]       coord_y,
    input  logic signed [COORD_BITS-1:0]       coord_z,
    output logic                               empty,
    input  logic                               pop,
    output logic [npsnap_pkg::IDX_W-1:0]       query_echo,
    output logic                               found,
    output logic [npsnap_pkg::IDX_W-1:0]       nearest_index,
    output logic signed [COORD_BITS-1:0]       snap_x,
    output logic signed [COORD_BITS-1:0]       snap_y,
    output logic signed [COORD_BITS-1:0]       snap_z
);
    import npsnap_pkg::*;

    logic [COUNT_W-1:0]          point_count_reg;
    logic                        cmd_valid;
    logic                        cmd_pop;
    cmd_t                        cmd;
    logic [2:0][COORD_BITS-1:0]  cmd_coord;
    logic                        reg_wr;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_POINT_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else if (reg_wr)
        begin
            point_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_POINT_COUNT)
        begin
            prdata = PDATA_W'(point_count_reg);
        end
    end

    npsnap_front #(
        .POINTS     (POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .point_slot  (point_slot),
        .query_index (query_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .point_count (point_count_reg),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd),
        .cmd_coord   (cmd_coord)
    );

    npsnap_scan #(
        .POINTS     (POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop),
        .cmd           (cmd),
        .cmd_coord     (cmd_coord),
        .empty         (empty),
        .pop           (pop),
        .query_echo    (query_echo),
        .found         (found),
        .nearest_index (nearest_index),
        .snap_x        (snap_x),
        .snap_y        (snap_y),
        .snap_z        (snap_z)
    );

endmodule

/* hdl/npsnap_front.sv */
// Front end of the nearest point snap block: accepts words, classifies them
// into load / scan / empty-search commands and queues them. Uses npsnap_pkg.
module npsnap_front #(
    parameter int POINTS     = npsnap_pkg::DEF_POINTS,
    parameter int COORD_BITS = npsnap_pkg::DEF_COORD_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               func,
    input  logic [npsnap_pkg::IDX_W-1:0]       point_slot,
    input  logic [npsnap_pkg::IDX_W-1:0]       query_index,
    input  logic signed [COORD_BITS-1:0]       coord_x,
    input  logic signed [COORD_BITS-1:0]       coord_y,
    input  logic signed [COORD_BITS-1:0]       coord_z,
    input  logic [npsnap_pkg::COUNT_W-1:0]     point_count,
    output logic                               cmd_valid,
    input  logic                               cmd_pop,
    output npsnap_pkg::cmd_t                   cmd,
    output logic [2:0][COORD_BITS-1:0]         cmd_coord
);
    import npsnap_pkg::*;

    cmd_t                        q_cmd_reg   [Q_DEPTH];
    logic [2:0][COORD_BITS-1:0]  q_coord_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]          wr_ptr_reg;
    logic [Q_PTR_W-1:0]          rd_ptr_reg;
    logic [Q_PTR_W:0]            cnt_reg;

    cmd_t                        new_cmd;
    logic                        load_ok;
    logic                        enq;
    logic                        deq;
    logic [COUNT_W-1:0]          n_eff;

    // Classify the incoming word
    always_comb
    begin
        load_ok = int'(point_slot) < POINTS;
        if (int'(point_count) > POINTS)
        begin
            n_eff = COUNT_W'(POINTS);
        end
        else
        begin
            n_eff = point_count;
        end
        new_cmd.slot = point_slot;
        new_cmd.qidx = query_index;
        new_cmd.n    = n_eff;
        if (func == FUNC_LOAD)
        begin
            new_cmd.op = CMD_LOAD;
        end
        else if (n_eff == '0)
        begin
            new_cmd.op = CMD_EMPTY;
        end
        else
        begin
            new_cmd.op = CMD_SCAN;
        end
    end

    assign full      = (cnt_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_cmd_reg[rd_ptr_reg];
    assign cmd_coord = q_coord_reg[rd_ptr_reg];

    // Drop loads aimed beyond the store
    assign enq = push && !full && !(func == FUNC_LOAD && !load_ok);
    assign deq = cmd_pop && cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (enq)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (enq && !deq)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (deq && !enq)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_cmd_reg[wr_ptr_reg]   <= new_cmd;
            q_coord_reg[wr_ptr_reg] <= {coord_z, coord_y, coord_x};
        end
    end

endmodule

/* hdl/npsnap_scan.sv */
// Back end of the nearest point snap block: point store, distance pipeline,
// running minimum and the result register. Uses npsnap_pkg.
module npsnap_scan #(
    parameter int POINTS     = npsnap_pkg::DEF_POINTS,
    parameter int COORD_BITS = npsnap_pkg::DEF_COORD_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_pop,
    input  npsnap_pkg::cmd_t                   cmd,
    input  logic [2:0][COORD_BITS-1:0]         cmd_coord,
    output logic                               empty,
    input  logic                               pop,
    output logic [npsnap_pkg::IDX_W-1:0]       query_echo,
    output logic                               found,
    output logic [npsnap_pkg::IDX_W-1:0]       nearest_index,
    output logic signed [COORD_BITS-1:0]       snap_x,
    output logic signed [COORD_BITS-1:0]       snap_y,
    output logic signed [COORD_BITS-1:0]       snap_z
);
    import npsnap_pkg::*;

    localparam int ADDR_W = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int SUM_W  = SQ_W + 2;

    logic [2:0][COORD_BITS-1:0] mem [POINTS];

    scan_state_t                 state_reg;
    scan_state_t                 state_next;

    logic [COUNT_W-1:0]          rd_idx_reg;
    logic [COUNT_W-1:0]          n_reg;
    logic [IDX_W-1:0]            qidx_reg;
    logic [2:0][COORD_BITS-1:0]  q_reg;

    // Pipeline: s1 read data, s2 abs diff, s3 squares, s4 sum
    logic                        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [COUNT_W-1:0]          s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [2:0][COORD_BITS-1:0]  s1_pt_reg, s2_pt_reg, s3_pt_reg, s4_pt_reg;
    logic [2:0][COORD_BITS-1:0]  s2_diff_reg;
    logic [2:0][SQ_W-1:0]        s3_sq_reg;
    logic [SUM_W-1:0]            s4_sum_reg;

    logic                        have_reg;
    logic [SUM_W-1:0]            best_sum_reg;
    logic [COUNT_W-1:0]          best_idx_reg;
    logic [2:0][COORD_BITS-1:0]  best_pt_reg;

    logic                        out_valid_reg;
    logic [IDX_W-1:0]            out_echo_reg;
    logic                        out_found_reg;
    logic [IDX_W-1:0]            out_idx_reg;
    logic [2:0][COORD_BITS-1:0]  out_pt_reg;

    logic                        issue;
    logic                        start;
    logic                        finish;
    logic                        mem_wr;
    logic                        last_issue;
    logic                        pipe_busy;
    logic                        better;
    logic [2:0][COORD_BITS-1:0]  abs_diff;
    logic [COORD_BITS:0]         diff_wide [3];

    assign last_issue = (rd_idx_reg == COUNT_W'(n_reg - 1'b1));
    assign pipe_busy  = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        CMD_SCAN:  state_next = S_SCAN;
                        CMD_EMPTY: state_next = S_DONE;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (last_issue)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        cmd_pop = 1'b0;
        issue   = 1'b0;
        finish  = 1'b0;
        unique case (state_reg)
            S_IDLE:  cmd_pop = cmd_valid;
            S_SCAN:  issue   = 1'b1;
            S_DRAIN: ;
            S_DONE:  finish  = !out_valid_reg;
        endcase
    end

    assign mem_wr = cmd_pop && (cmd.op == CMD_LOAD);
    assign start  = cmd_pop && (cmd.op != CMD_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Point store: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[ADDR_W'(cmd.slot)] <= cmd_coord;
        end
        if (issue)
        begin
            s1_pt_reg <= mem[ADDR_W'(rd_idx_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= cmd.n;
            qidx_reg <= cmd.qidx;
            q_reg    <= cmd_coord;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
        end
        else if (start)
        begin
            rd_idx_reg <= '0;
        end
        else if (issue)
        begin
            rd_idx_reg <= rd_idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff_wide[k] = $signed({q_reg[k][COORD_BITS-1], q_reg[k]})
                         - $signed({s1_pt_reg[k][COORD_BITS-1], s1_pt_reg[k]});
            if (diff_wide[k][COORD_BITS])
            begin
                abs_diff[k] = COORD_BITS'(-diff_wide[k]);
            end
            else
            begin
                abs_diff[k] = diff_wide[k][COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= rd_idx_reg;
        s2_idx_reg  <= s1_idx_reg;
        s2_pt_reg   <= s1_pt_reg;
        s2_diff_reg <= abs_diff;
        s3_idx_reg  <= s2_idx_reg;
        s3_pt_reg   <= s2_pt_reg;
        for (int k = 0; k < 3; k++)
        begin
            s3_sq_reg[k] <= SQ_W'(s2_diff_reg[k]) * SQ_W'(s2_diff_reg[k]);
        end
        s4_idx_reg  <= s3_idx_reg;
        s4_pt_reg   <= s3_pt_reg;
        s4_sum_reg  <= SUM_W'(s3_sq_reg[0]) + SUM_W'(s3_sq_reg[1]) + SUM_W'(s3_sq_reg[2]);
    end

    // Strictly less keeps the lowest index on a tie
    assign better = s4_valid_reg && (!have_reg || (s4_sum_reg < best_sum_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (start)
        begin
            have_reg <= 1'b0;
        end
        else if (better)
        begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (better)
        begin
            best_sum_reg <= s4_sum_reg;
            best_idx_reg <= s4_idx_reg;
            best_pt_reg  <= s4_pt_reg;
        end
    end

    // Result word; hold until popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_echo_reg  <= qidx_reg;
            out_found_reg <= have_reg;
            out_idx_reg   <= have_reg ? best_idx_reg[IDX_W-1:0] : '0;
            out_pt_reg    <= have_reg ? best_pt_reg : '0;
        end
    end

    assign empty         = !out_valid_reg;
    assign query_echo    = out_echo_reg;
    assign found         = out_found_reg;
    assign nearest_index = out_idx_reg;
    assign snap_x        = out_pt_reg[0];
    assign snap_y        = out_pt_reg[1];
    assign snap_z        = out_pt_reg[2];

endmodule
